### hw/rtl/gpmc_pkg.sv
// Shared types, register codes and the output conditioning function.
`default_nettype none

package gpmc_pkg;

  localparam int unsigned RateW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned StepW  = 11;
  localparam int unsigned SmthW  = 24;
  localparam int unsigned RawW   = 21;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_MOTION_THR = 3'd0,
    REG_SLEEP_TMO  = 3'd1,
    REG_DTAP       = 3'd2,
    REG_DEAD_ZONE  = 3'd3,
    REG_PTR_GAIN   = 3'd4,
    REG_SCR_GAIN   = 3'd5,
    REG_SMOOTH_W   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] motion_threshold;
    logic [31:0] sleep_timeout_ms;
    logic [15:0] double_tap_ms;
    logic [7:0]  dead_zone;
    logic [4:0]  pointer_gain;
    logic [4:0]  scroll_gain;
    logic [8:0]  smooth_weight;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOTION,
    ST_CHECK,
    ST_MUL,
    ST_WGT,
    ST_ACC,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic motion;
    logic check;
    logic mul;
    logic wgt;
    logic acc;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic awake;
    logic out_free;
  } sts_t;

  // Q.10 value -> integer step: truncate toward zero, dead zone, clamp to +-1023
  function automatic logic signed [StepW-1:0] condition_q10(
    input logic signed [SmthW-1:0] q,
    input logic [7:0]              dz
  );
    logic signed [SmthW-1:0] biased;
    logic signed [13:0]      m;
    logic [13:0]             mag;
    logic signed [StepW-1:0] r;
    biased = q[SmthW-1] ? q + 24'sd1023 : q;
    m      = biased[SmthW-1:10];
    mag    = m[13] ? 14'(-m) : 14'(m);
    if (mag < 14'(dz)) begin
      r = '0;
    end else if (m > 14'sd1023) begin
      r = 11'sd1023;
    end else if (m < -14'sd1023) begin
      r = -11'sd1023;
    end else begin
      r = m[StepW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gyro_pointer_motion_conditioner_core.sv
// Top level of the gyro pointer motion conditioner.
// Usage:
//   Slave stream: one beat per gyro sample. s_tdata carries three Q5.10 rates and
//   a millisecond timestamp; s_tuser carries the button pin level (0 = pressed).
//   Master stream: one beat per sample taken while awake, carrying pointer steps,
//   the wheel step and the drag/scroll flags. Sleeping samples produce no beat.
//   Config: APB-style port, seven 32-bit registers at byte addresses 0x00..0x18;
//   write only while no sample is in flight. pready is tied high.
// Timing:
//   A sample runs through a seven-state sequencer: accept, motion test, sleep and
//   button check, gain multiply, filter weight multiply, accumulate, emit. An
//   awake sample passes through every state before the next accept and its beat
//   is registered at emit; a sleeping sample returns to accept after the check.
//   The chain of dependent multiplies in the filter sets the awake path length.
// Stall:
//   The output register holds its beat while m_tready is low; the next sample is
//   still accepted and runs until its emit step, where it waits for the register.
// Reset:
//   rst (synchronous) restores register defaults, wakes the block, selects
//   pointer mode, releases the button and clears both filters and m_tvalid.
`default_nettype none

module gyro_pointer_motion_conditioner_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // sample stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,  // rate_x[15:0], rate_y[31:16], rate_z[47:32], now_ms[79:48]
  input  wire logic        s_tuser,  // button_level[0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // move_x[10:0], move_y[21:11], wheel[32:22], zero pad
  output logic [1:0]       m_tuser,  // left_held[0], in_scroll[1]
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  gpmc_pkg::cfg_t cfg;
  gpmc_pkg::cmd_t cmd;
  gpmc_pkg::sts_t sts;

  gpmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gpmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gpmc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .in_data   (s_tdata),
    .in_level  (s_tuser),
    .out_data  (m_tdata),
    .out_flags (m_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

endmodule

`default_nettype wire

### hw/rtl/gpmc_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module gpmc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gpmc_pkg::AddrW-1:0] paddr,
  input  wire logic [gpmc_pkg::DataW-1:0] pwdata,
  output logic      [gpmc_pkg::DataW-1:0] prdata,
  output logic                            pready,
  output gpmc_pkg::cfg_t                  cfg
);

  logic               wr_en;
  gpmc_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = gpmc_pkg::reg_idx_t'(paddr[gpmc_pkg::AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motion_threshold <= 16'd307;
      cfg.sleep_timeout_ms <= 32'd10000;
      cfg.double_tap_ms    <= 16'd300;
      cfg.dead_zone        <= 8'd2;
      cfg.pointer_gain     <= 5'd8;
      cfg.scroll_gain      <= 5'd3;
      cfg.smooth_weight    <= 9'd51;
    end else if (wr_en) begin
      case (idx)
        gpmc_pkg::REG_MOTION_THR: cfg.motion_threshold <= pwdata[15:0];
        gpmc_pkg::REG_SLEEP_TMO:  cfg.sleep_timeout_ms <= pwdata;
        gpmc_pkg::REG_DTAP:       cfg.double_tap_ms    <= pwdata[15:0];
        gpmc_pkg::REG_DEAD_ZONE:  cfg.dead_zone        <= pwdata[7:0];
        gpmc_pkg::REG_PTR_GAIN:   cfg.pointer_gain     <= pwdata[4:0];
        gpmc_pkg::REG_SCR_GAIN:   cfg.scroll_gain      <= pwdata[4:0];
        gpmc_pkg::REG_SMOOTH_W:   cfg.smooth_weight    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gpmc_pkg::REG_MOTION_THR: prdata = 32'(cfg.motion_threshold);
      gpmc_pkg::REG_SLEEP_TMO:  prdata = cfg.sleep_timeout_ms;
      gpmc_pkg::REG_DTAP:       prdata = 32'(cfg.double_tap_ms);
      gpmc_pkg::REG_DEAD_ZONE:  prdata = 32'(cfg.dead_zone);
      gpmc_pkg::REG_PTR_GAIN:   prdata = 32'(cfg.pointer_gain);
      gpmc_pkg::REG_SCR_GAIN:   prdata = 32'(cfg.scroll_gain);
      gpmc_pkg::REG_SMOOTH_W:   prdata = 32'(cfg.smooth_weight);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/gpmc_ctrl.sv
// Sequencer: steps one sample through the datapath.
`default_nettype none

module gpmc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire gpmc_pkg::sts_t sts,
  output gpmc_pkg::cmd_t      cmd
);

  gpmc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      gpmc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = gpmc_pkg::ST_MOTION;
        end
      end
      gpmc_pkg::ST_MOTION: begin
        cmd.motion = 1'b1;
        state_next = gpmc_pkg::ST_CHECK;
      end
      gpmc_pkg::ST_CHECK: begin
        cmd.check  = 1'b1;
        // sleeping samples end here with no beat
        state_next = sts.awake ? gpmc_pkg::ST_MUL : gpmc_pkg::ST_IDLE;
      end
      gpmc_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = gpmc_pkg::ST_WGT;
      end
      gpmc_pkg::ST_WGT: begin
        cmd.wgt    = 1'b1;
        state_next = gpmc_pkg::ST_ACC;
      end
      gpmc_pkg::ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = gpmc_pkg::ST_EMIT;
      end
      gpmc_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = gpmc_pkg::ST_IDLE;
        end
      end
      default: state_next = gpmc_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/gpmc_datapath.sv
// Datapath: wake/sleep, button and scroll state, smoothing filters, output register.
`default_nettype none

module gpmc_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire gpmc_pkg::cmd_t cmd,
  output gpmc_pkg::sts_t      sts,
  input  wire gpmc_pkg::cfg_t cfg,
  input  wire logic [79:0]    in_data,
  input  wire logic           in_level,
  output logic [39:0]         out_data,
  output logic [1:0]          out_flags,
  output logic                out_valid,
  input  wire logic           out_ready
);

  // sample registers
  logic signed [15:0] rx, ry, rz;
  logic               lvl;
  logic [31:0]        now;

  // block state
  logic [31:0]        last_motion_time;
  logic               asleep;
  logic               scroll_on;
  logic [31:0]        last_press_time;
  logic               prev_level;
  logic               drag_on;
  logic signed [23:0] smooth_horiz, smooth_vert;

  // arithmetic intermediates
  logic signed [20:0] raw_h, raw_v, raw_w;
  logic signed [33:0] ph_old, pv_old;
  logic signed [30:0] ph_new, pv_new;

  // output beat
  logic signed [10:0] move_x, move_y, wheel;
  logic               left_held, in_scroll;

  logic [16:0]        abs_x, abs_y, abs_z;
  logic [17:0]        movement;
  logic [31:0]        idle_ms, tap_ms;
  logic               timed_out, press;
  logic [8:0]         w_new, w_old;
  logic signed [21:0] prod_h, prod_v, prod_w;
  logic signed [34:0] sum_h, sum_v;

  assign abs_x    = rx[15] ? 17'(-18'(rx)) : 17'(rx);
  assign abs_y    = ry[15] ? 17'(-18'(ry)) : 17'(ry);
  assign abs_z    = rz[15] ? 17'(-18'(rz)) : 17'(rz);
  assign movement = 18'(abs_x) + 18'(abs_y) + 18'(abs_z);

  assign idle_ms   = now - last_motion_time;
  assign timed_out = idle_ms > cfg.sleep_timeout_ms;
  assign tap_ms    = now - last_press_time;
  assign press     = prev_level & ~lvl;

  assign w_new  = (cfg.smooth_weight > 9'd256) ? 9'd256 : cfg.smooth_weight;
  assign w_old  = 9'd256 - w_new;

  assign prod_h = rz * $signed({1'b0, cfg.pointer_gain});
  assign prod_v = rx * $signed({1'b0, cfg.pointer_gain});
  assign prod_w = rx * $signed({1'b0, cfg.scroll_gain});

  assign sum_h  = 35'(ph_old) + 35'(ph_new);
  assign sum_v  = 35'(pv_old) + 35'(pv_new);

  assign sts.awake    = ~(asleep | timed_out);
  assign sts.out_free = ~out_valid | out_ready;

  assign out_data  = {7'b0, wheel, move_y, move_x};
  assign out_flags = {in_scroll, left_held};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rx  <= in_data[15:0];
      ry  <= in_data[31:16];
      rz  <= in_data[47:32];
      now <= in_data[79:48];
      lvl <= in_level;
    end
    if (cmd.mul) begin
      raw_h <= prod_h[20:0];
      raw_v <= prod_v[20:0];
      raw_w <= prod_w[20:0];
    end
    if (cmd.wgt) begin
      ph_old <= smooth_horiz * $signed({1'b0, w_old});
      pv_old <= smooth_vert  * $signed({1'b0, w_old});
      ph_new <= raw_h * $signed({1'b0, w_new});
      pv_new <= raw_v * $signed({1'b0, w_new});
    end
    if (cmd.emit) begin
      left_held <= drag_on;
      in_scroll <= scroll_on;
      if (scroll_on) begin
        move_x <= '0;
        move_y <= '0;
        wheel  <= gpmc_pkg::condition_q10(24'(raw_w), cfg.dead_zone);
      end else begin
        move_x <= gpmc_pkg::condition_q10(smooth_horiz, cfg.dead_zone);
        move_y <= gpmc_pkg::condition_q10(smooth_vert, cfg.dead_zone);
        wheel  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_motion_time <= '0;
      asleep           <= 1'b0;
      scroll_on        <= 1'b0;
      last_press_time  <= '0;
      prev_level       <= 1'b1;
      drag_on          <= 1'b0;
      smooth_horiz     <= '0;
      smooth_vert      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.motion && (movement > 18'(cfg.motion_threshold))) begin
        last_motion_time <= now;
        asleep           <= 1'b0;
      end
      if (cmd.check) begin
        asleep <= asleep | timed_out;
        if (sts.awake) begin
          if (press) begin
            if (tap_ms < 32'(cfg.double_tap_ms)) begin
              scroll_on <= ~scroll_on;
            end
            last_press_time <= now;
          end
          prev_level <= lvl;
          drag_on    <= ~lvl;
        end
      end
      if (cmd.acc) begin
        // floor divide by 256
        smooth_horiz <= sum_h[31:8];
        smooth_vert  <= sum_v[31:8];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gpmc_checker.sv
// Port-level checks for the conditioner, bound to the top level.
`default_nettype none

module gpmc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // a stalled beat is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present after reset");

  // one sample at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second sample accepted while one is in flight");

  // wheel only in scroll mode, pointer steps only in pointer mode
  a_mode_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[1] ? (m_tdata[21:0] == 22'd0) : (m_tdata[32:22] == 11'd0)))
    else $error("motion field does not match scroll mode");

endmodule

bind gyro_pointer_motion_conditioner_core gpmc_checker u_gpmc_checker (.*);

`default_nettype wire

### sim/tb_gyro_pointer_motion_conditioner_core.sv
// Self-checking testbench for the gyro pointer motion conditioner core.
`default_nettype none

module tb_gyro_pointer_motion_conditioner_core;

  localparam int StepMax = 1023;
  // Quiet cycles after the last beat, enough for a sample still in flight, awake
  // or sleeping, to finish and for the sequencer to be back in idle.
  localparam int SettleCycles = 12;
  // Longest honest quiet stretch: a sender gap, a full sequencer pass and a sink
  // stall, or a drain plus settle before register writes. Taken many times.
  localparam int IdleLimit = 400;
  localparam int ResultsPerPhase = 100;

  // One gyro sample as it goes onto the slave stream.
  typedef struct {
    logic signed [gpmc_pkg::RateW-1:0] rate_x;
    logic signed [gpmc_pkg::RateW-1:0] rate_y;
    logic signed [gpmc_pkg::RateW-1:0] rate_z;
    logic                              button_level;
    logic [gpmc_pkg::TimeW-1:0]        now_ms;
  } sample_t;

  // One pointer/wheel report as it should leave the master stream.
  typedef struct {
    logic signed [gpmc_pkg::StepW-1:0] move_x;
    logic signed [gpmc_pkg::StepW-1:0] move_y;
    logic signed [gpmc_pkg::StepW-1:0] wheel;
    logic                              left_held;
    logic                              in_scroll;
  } step_t;

  // Mirror of the conditioner: register copies, block state, and the queue
  // of reports still owed by the block.
  class motion_scoreboard;
    step_t       expected_q[$];
    int          errors;
    int          predicted;
    int          checked;
    int          dropped;
    logic [15:0] thr;
    logic [31:0] tmo;
    logic [15:0] dtap;
    logic [7:0]  dz;
    logic [4:0]  pgain;
    logic [4:0]  sgain;
    logic [8:0]  wgt;
    logic [31:0] last_motion;
    logic [31:0] last_press;
    bit          asleep;
    bit          scroll_on;
    bit          prev_level;
    bit          drag_on;
    int          smooth_h;
    int          smooth_v;

    function new();
      thr         = 16'd307;
      tmo         = 32'd10000;
      dtap        = 16'd300;
      dz          = 8'd2;
      pgain       = 5'd8;
      sgain       = 5'd3;
      wgt         = 9'd51;
      last_motion = '0;
      last_press  = '0;
      asleep      = 0;
      scroll_on   = 0;
      prev_level  = 1;
      drag_on     = 0;
      smooth_h    = 0;
      smooth_v    = 0;
      errors      = 0;
      predicted   = 0;
      checked     = 0;
      dropped     = 0;
    endfunction

    function void set_reg(gpmc_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        gpmc_pkg::REG_MOTION_THR: thr   = v[15:0];
        gpmc_pkg::REG_SLEEP_TMO:  tmo   = v;
        gpmc_pkg::REG_DTAP:       dtap  = v[15:0];
        gpmc_pkg::REG_DEAD_ZONE:  dz    = v[7:0];
        gpmc_pkg::REG_PTR_GAIN:   pgain = v[4:0];
        gpmc_pkg::REG_SCR_GAIN:   sgain = v[4:0];
        gpmc_pkg::REG_SMOOTH_W:   wgt   = v[8:0];
        default: ;
      endcase
    endfunction

    // first-order filter, weight clipped to 256, floor division by 256
    function int filter_next(int s, int raw);
      longint w;
      longint acc;
      w   = (wgt > 9'd256) ? 256 : longint'(wgt);
      acc = longint'(s) * (256 - w) + longint'(raw) * w;
      return int'(acc >>> 8);
    endfunction

    // Q.10 -> integer step: truncate toward zero, dead zone, clamp
    function int clip_step(int q);
      int m;
      m = q / 1024;
      if ((m < 0 ? -m : m) < int'(dz)) m = 0;
      if (m > StepMax) m = StepMax;
      if (m < -StepMax) m = -StepMax;
      return m;
    endfunction

    function void note_sample(sample_t smp);
      int          rx;
      int          ry;
      int          rz;
      int          mx;
      int          my;
      int          wh;
      int unsigned movement;
      logic [31:0] gap;
      step_t       e;
      rx = smp.rate_x;
      ry = smp.rate_y;
      rz = smp.rate_z;
      movement = (rx < 0 ? -rx : rx) + (ry < 0 ? -ry : ry) + (rz < 0 ? -rz : rz);
      if (movement > thr) begin
        last_motion = smp.now_ms;
        asleep      = 0;
      end
      gap = smp.now_ms - last_motion;
      if (gap > tmo) asleep = 1;
      if (asleep) begin
        dropped++;
        return;
      end
      // falling edge of the pin is a press; two quick presses flip scroll mode
      if (prev_level && !smp.button_level) begin
        gap = smp.now_ms - last_press;
        if (gap < dtap) scroll_on = !scroll_on;
        last_press = smp.now_ms;
      end
      prev_level = smp.button_level;
      drag_on    = !smp.button_level;
      // horizontal follows z, vertical follows x; filters run in scroll mode too
      smooth_h = filter_next(smooth_h, rz * int'(pgain));
      smooth_v = filter_next(smooth_v, rx * int'(pgain));
      if (scroll_on) begin
        mx = 0;
        my = 0;
        wh = clip_step(rx * int'(sgain));
      end else begin
        mx = clip_step(smooth_h);
        my = clip_step(smooth_v);
        wh = 0;
      end
      e.move_x    = mx[gpmc_pkg::StepW-1:0];
      e.move_y    = my[gpmc_pkg::StepW-1:0];
      e.wheel     = wh[gpmc_pkg::StepW-1:0];
      e.left_held = drag_on;
      e.in_scroll = scroll_on;
      expected_q.push_back(e);
      predicted++;
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_step(logic [39:0] d, logic [1:0] u);
      step_t e;
      int    got[6];
      int    want[6];
      string names[6];
      names = '{"move_x", "move_y", "wheel", "pad", "left_held", "in_scroll"};
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected: tdata %h tuser %b",
                         checked, d, u));
        return;
      end
      e = expected_q.pop_front();
      got  = '{int'($signed(d[10:0])), int'($signed(d[21:11])), int'($signed(d[32:22])),
               int'(d[39:33]), int'(u[0]), int'(u[1])};
      want = '{int'(e.move_x), int'(e.move_y), int'(e.wheel), 0,
               int'(e.left_held), int'(e.in_scroll)};
      for (int i = 0; i < 6; i++) begin
        if (got[i] != want[i])
          report($sformatf("beat %0d %s: got %0d, want %0d", checked, names[i],
                           got[i], want[i]));
      end
    endtask

    function bit pending();
      return expected_q.size() != 0;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // rate_x[15:0], rate_y[31:16], rate_z[47:32], now_ms[79:48]
  logic        s_tuser = 1'b1; // button_level[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // move_x[10:0], move_y[21:11], wheel[32:22], zero pad
  logic [1:0]  m_tuser;        // left_held[0], in_scroll[1]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  motion_scoreboard           sb;
  logic [gpmc_pkg::TimeW-1:0] cur_ms = '0;
  logic                       btn_level = 1'b1;
  bit                         steady = 0;    // both sides run without gaps while set
  int                         sent = 0;
  int                         settings = 1;  // reset values count as the first setting
  int                         idle_cycles = 0;

  always #5 clk = ~clk;

  gyro_pointer_motion_conditioner_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Push one sample after a random gap (none while steady is set); returns at the edge it is taken.
  task automatic send_sample(input logic signed [gpmc_pkg::RateW-1:0] rx, ry, rz,
                             input logic lvl, input logic [gpmc_pkg::TimeW-1:0] now);
    int      gap;
    sample_t smp;
    smp.rate_x       = rx;
    smp.rate_y       = ry;
    smp.rate_z       = rz;
    smp.button_level = lvl;
    smp.now_ms       = now;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, rz, ry, rx};
    s_tuser  <= lvl;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(smp);
    sent++;
  endtask

  // Stop sending until every owed report is out and the sequencer is idle.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending());
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen.
  task automatic write_reg(gpmc_pkg::reg_idx_t idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [31:0] thr, tmo, dtap, dz, pg, sg, w);
    write_reg(gpmc_pkg::REG_MOTION_THR, thr);
    write_reg(gpmc_pkg::REG_SLEEP_TMO, tmo);
    write_reg(gpmc_pkg::REG_DTAP, dtap);
    write_reg(gpmc_pkg::REG_DEAD_ZONE, dz);
    write_reg(gpmc_pkg::REG_PTR_GAIN, pg);
    write_reg(gpmc_pkg::REG_SCR_GAIN, sg);
    write_reg(gpmc_pkg::REG_SMOOTH_W, w);
    settings++;
  endtask

  // rate classes: near rest, ordinary hand motion, anything at all
  function automatic logic signed [gpmc_pkg::RateW-1:0] rand_rate(int cls);
    int v;
    case (cls)
      0:       v = $urandom_range(0, 100) - 50;
      1:       v = $urandom_range(0, 4096) - 2048;
      default: v = $urandom;
    endcase
    return v[gpmc_pkg::RateW-1:0];
  endfunction

  // Mostly plausible traces: steady time steps, wrist motion, button taps a
  // few tens of ms apart. Mixed in: time jumps that put the block to sleep,
  // gaps near the double-tap window, and fully random samples.
  task automatic random_phase(int target);
    int                                start;
    int                                n;
    int                                k;
    int                                cls;
    logic signed [gpmc_pkg::RateW-1:0] rx;
    logic signed [gpmc_pkg::RateW-1:0] ry;
    logic signed [gpmc_pkg::RateW-1:0] rz;
    start = sb.predicted;
    n = 0;
    while (sb.predicted - start < target && n < 8 * target) begin
      steady = (n >= 30 && n < 60);
      k = $urandom_range(0, 99);
      if (k < 90) cur_ms += $urandom_range(0, 25);
      else if (k < 95) cur_ms += $urandom_range(200, 400);
      else cur_ms += $urandom;
      k = $urandom_range(0, 99);
      cls = (k < 20) ? 0 : (k < 75) ? 1 : 2;
      rx = rand_rate(cls);
      ry = rand_rate(cls);
      rz = rand_rate(cls);
      if ($urandom_range(0, 3) == 0) btn_level = !btn_level;
      if ($urandom_range(0, 9) == 0) begin
        rx        = rand_rate(2);
        ry        = rand_rate(2);
        rz        = rand_rate(2);
        cur_ms    = $urandom;
        btn_level = 1'($urandom_range(0, 1));
      end
      send_sample(rx, ry, rz, btn_level, cur_ms);
      if ($urandom_range(0, 49) == 0) hold_until_drained();
      n++;
    end
    steady = 0;
  endtask

  // Result side: random stall before each beat, none while steady is set.
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_step(m_tdata, m_tuser);
    end
  end

  // Watchdog: too long without any beat or register access ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: %0d cycles without progress", idle_cycles);
        $display("tb_gyro_pointer_motion_conditioner_core: done, errors");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset register values (threshold 307, timeout 10 s,
    // double tap 300 ms, dead zone 2, gains 8 and 3, weight 51).
    send_sample(0, 0, 0, 1'b1, 32'd0);                  // at rest, time zero
    send_sample(32767, 32767, 32767, 1'b1, 32'd10);     // largest rates
    send_sample(-32768, -32768, -32768, 1'b1, 32'd20);  // most negative rates
    send_sample(1000, -500, 300, 1'b0, 32'd30);         // press: drag starts, 30 ms on: scroll on
    send_sample(1000, -500, 300, 1'b0, 32'd40);         // still held
    send_sample(1000, -500, 300, 1'b1, 32'd50);         // release
    send_sample(2000, 0, 0, 1'b0, 32'd120);             // second press 90 ms on: scroll off
    send_sample(32767, 0, 0, 1'b0, 32'd130);            // pointer, top rate
    send_sample(-32768, 0, 0, 1'b1, 32'd140);           // pointer, bottom rate
    send_sample(500, 0, 0, 1'b0, 32'd440);              // 320 ms after press: no toggle
    send_sample(500, 0, 0, 1'b1, 32'd450);
    send_sample(500, 0, 0, 1'b0, 32'd739);              // 299 ms: toggles scroll on
    send_sample(500, 0, 0, 1'b1, 32'd750);
    send_sample(0, 0, 0, 1'b1, 32'd20751);              // quiet past timeout: asleep
    send_sample(0, 0, 0, 1'b0, 32'd20760);              // press while asleep is ignored
    send_sample(100, 100, 100, 1'b1, 32'd20770);        // sum 300, not above threshold
    send_sample(200, 100, 8, 1'b1, 32'd20780);          // sum 308 wakes the block
    send_sample(400, 0, 0, 1'b1, 32'hFFFF_FFF0);        // just before the time wraps
    send_sample(0, 0, 0, 1'b1, 32'h0000_0005);          // after the wrap, still awake
    send_sample(-1, -1, -1, 1'b0, 32'd10);              // tiny negative: truncation
    send_sample(0, 0, -2000, 1'b0, 32'd20);
    send_sample(-3000, 0, 3000, 1'b1, 32'd30);
    cur_ms = 32'd30;

    // All registers at zero, then all ones (upper bits dropped, weight above
    // 256 saturates), then a full-weight setting, then random settings.
    hold_until_drained();
    apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_phase(ResultsPerPhase);
    hold_until_drained();
    apply_settings('1, '1, '1, '1, '1, '1, '1);
    random_phase(ResultsPerPhase);
    hold_until_drained();
    apply_settings(32'd500, 32'd2000, 32'd250, 32'd0, 32'd31, 32'd31, 32'd256);
    random_phase(ResultsPerPhase);
    repeat (5) begin
      hold_until_drained();
      apply_settings($urandom_range(0, 3000),
                     $urandom_range(0, 1) ? $urandom_range(0, 3000)
                                          : $urandom_range(3000, 100000),
                     $urandom_range(0, 600), $urandom_range(0, 6),
                     $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 300));
      random_phase(ResultsPerPhase);
    end
    hold_until_drained();

    $display("run covered %0d samples under %0d register settings", sent, settings);
    $display("%0d reports checked, %0d samples taken while asleep", sb.checked, sb.dropped);
    if (sb.errors == 0) begin
      $display("tb_gyro_pointer_motion_conditioner_core: done, clean");
    end else begin
      $display("tb_gyro_pointer_motion_conditioner_core: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

### gyro_pointer_motion_conditioner_core.f
hw/rtl/gpmc_pkg.sv
hw/rtl/gpmc_regs.sv
hw/rtl/gpmc_ctrl.sv
hw/rtl/gpmc_datapath.sv
hw/rtl/gyro_pointer_motion_conditioner_core.sv
hw/rtl/gpmc_checker.sv
sim/tb_gyro_pointer_motion_conditioner_core.sv
